// ----- src/assert_macros.svh -----
// Assertion macros shared by the drive mixer RTL.
// ASSERT_CLK expects clk and rst_n in the scope where it is used; ASSERT_RST only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- src/tjdm_pkg.sv -----
// Package for the tilt joystick drive mixer: widths, register indices,
// fixed-point constants and the shake limit struct. No dependencies.
package tjdm_pkg;

  localparam int AXIS_W      = 16;
  localparam int TIME_W      = 32;
  localparam int SPEED_W     = 16;
  localparam int ANGLE_W     = 11;
  localparam int THR_W       = 11;
  localparam int DZ_W        = 12;
  localparam int HOLD_W      = 16;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAKE_THR  = 3'd0,
    REG_DEAD_ZONE  = 3'd1,
    REG_HOLDOFF    = 3'd2,
    REG_ANGLE_HIGH = 3'd3,
    REG_ANGLE_LOW  = 3'd4
  } cfg_reg_t;

  localparam logic [THR_W-1:0]  THR_RST        = 11'd500;
  localparam logic [DZ_W-1:0]   DZ_RST         = 12'd208;
  localparam logic [HOLD_W-1:0] HOLD_RST       = 16'd750;
  localparam logic [ANGLE_W-1:0] ANGLE_HIGH_RST = 11'sd300;
  localparam logic [ANGLE_W-1:0] ANGLE_LOW_RST  = 11'd0;

  // wheel speed: q = round(mag * 4000 / 9810) = ((mag*4000 + 4905) * M) >> 42
  localparam int SUM_W  = 18;
  localparam int MAG_W  = 17;
  localparam int NUM_W  = 28;
  localparam int PROD_W = 57;
  localparam int Q_W    = 15;
  localparam int SPD_SHIFT = 42;
  localparam logic [NUM_W-1:0] SPD_ROUND = 28'd4905;
  localparam logic [28:0]      SPD_RECIP = 29'd448322785;

  // shake limits: m2 against (1000 +/- t)^2 * 962361 / 10000
  localparam int SHAKE_UNIT = 1000;
  localparam int SQ_W   = 24;
  localparam int FRAC_W = 35;
  localparam int BASE_W = 30;
  localparam int LIM_W  = 32;
  localparam logic [11:0]        FRAC_MUL  = 12'd2361;
  localparam logic [FRAC_W-1:0]  CEIL_PAD  = 35'd9999;
  localparam logic [31:0]        DIV_RECIP = 32'd3518437209;
  localparam int DIV_SHIFT = 41;

  localparam logic [1:0] SETTLE_CYC = 2'd3;

  typedef struct packed {
    logic [LIM_W-1:0] hi;
    logic [LIM_W-1:0] lo;
    logic             lo_en;
  } shake_lim_t;

endpackage

// ----- src/tjdm_shake_lim.sv -----
// Shake limit pipeline: turns the threshold register into squared-magnitude
// limits over three register stages. Depends on tjdm_pkg.
module tjdm_shake_lim (
  input  logic                          clk,
  input  logic [tjdm_pkg::THR_W-1:0]    thr,
  output tjdm_pkg::shake_lim_t          lim
);

  // floor(y / 10000) as floor(floor(y / 16) / 625) by reciprocal
  function automatic logic [21:0] div10k(input logic [tjdm_pkg::FRAC_W-1:0] y);
    logic [30:0] n;
    logic [62:0] p;
    n = y[tjdm_pkg::FRAC_W-1:4];
    p = 63'(n) * 63'(tjdm_pkg::DIV_RECIP);
    return p[62:tjdm_pkg::DIV_SHIFT];
  endfunction

  logic [11:0]                  hi_base;
  logic [11:0]                  lo_base;
  logic                         lo_en;
  logic [tjdm_pkg::SQ_W-1:0]    hi_a_r, lo_a_r;
  logic                         en1_r, en2_r;
  logic [tjdm_pkg::FRAC_W-1:0]  hi_x_r, lo_x_r;
  logic [tjdm_pkg::BASE_W-1:0]  hi_b_r, lo_b_r;
  tjdm_pkg::shake_lim_t         lim_r;

  assign hi_base = 12'(tjdm_pkg::SHAKE_UNIT) + 12'(thr);
  assign lo_base = 12'(tjdm_pkg::SHAKE_UNIT) - 12'(thr);
  assign lo_en   = thr < 11'(tjdm_pkg::SHAKE_UNIT);

  always_ff @(posedge clk) begin
    // stage 1: squares of the band edges, in milli-g
    hi_a_r <= 24'(hi_base) * 24'(hi_base);
    lo_a_r <= lo_en ? 24'(lo_base) * 24'(lo_base) : '0;
    en1_r  <= lo_en;
    // stage 2: split 962361 into 96 * 10000 + 2361
    hi_x_r <= 35'(hi_a_r) * 35'(tjdm_pkg::FRAC_MUL);
    lo_x_r <= 35'(lo_a_r) * 35'(tjdm_pkg::FRAC_MUL) + tjdm_pkg::CEIL_PAD;
    hi_b_r <= (30'(hi_a_r) << 6) + (30'(hi_a_r) << 5);
    lo_b_r <= (30'(lo_a_r) << 6) + (30'(lo_a_r) << 5);
    en2_r  <= en1_r;
    // stage 3: high limit rounds down, low limit rounds up
    lim_r.hi    <= 32'(hi_b_r) + 32'(div10k(hi_x_r));
    lim_r.lo    <= 32'(lo_b_r) + 32'(div10k(lo_x_r));
    lim_r.lo_en <= en2_r;
  end

  assign lim = lim_r;

endmodule

// ----- src/tjdm_wheel.sv -----
// One wheel: scale a mixed axis sum to 1/16 mm/s and apply the dead zone.
// Combinational; depends on tjdm_pkg.
module tjdm_wheel (
  input  logic signed [tjdm_pkg::SUM_W-1:0]   sum,
  input  logic        [tjdm_pkg::DZ_W-1:0]    dead_zone,
  output logic signed [tjdm_pkg::SPEED_W-1:0] speed
);

  logic                          neg;
  logic [tjdm_pkg::MAG_W-1:0]    mag;
  logic [tjdm_pkg::NUM_W-1:0]    num;
  logic [tjdm_pkg::PROD_W-1:0]   prod;
  logic [tjdm_pkg::Q_W-1:0]      q;
  logic [tjdm_pkg::Q_W-1:0]      v;

  assign neg  = sum[tjdm_pkg::SUM_W-1];
  assign mag  = neg ? 17'(-sum) : 17'(sum);
  // mag * 4000 = mag * (4096 - 64 - 32), plus half the divisor for rounding
  assign num  = (28'(mag) << 12) - (28'(mag) << 6) - (28'(mag) << 5)
              + tjdm_pkg::SPD_ROUND;
  assign prod = 57'(num) * 57'(tjdm_pkg::SPD_RECIP);
  assign q    = prod[tjdm_pkg::PROD_W-1:tjdm_pkg::SPD_SHIFT];

  // q tops out near 26721, so the shrunk value always fits 16 bits signed
  assign v     = (q < 15'(dead_zone)) ? '0 : q - 15'(dead_zone);
  assign speed = neg ? -$signed(16'(v)) : $signed(16'(v));

endmodule

// ----- src/tjdm_lift.sv -----
// Shake detector and lift state: squared magnitude test, wrap-safe holdoff,
// lift toggle and last toggle time. Depends on tjdm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tjdm_lift (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic signed [tjdm_pkg::AXIS_W-1:0]   accel_x,
  input  logic signed [tjdm_pkg::AXIS_W-1:0]   accel_y,
  input  logic signed [tjdm_pkg::AXIS_W-1:0]   accel_z,
  input  logic        [tjdm_pkg::TIME_W-1:0]   time_ms,
  input  tjdm_pkg::shake_lim_t                 lim,
  input  logic        [tjdm_pkg::HOLD_W-1:0]   holdoff,
  output logic                                 lift_up,
  output logic                                 toggled
);

  logic signed [31:0]               px, py, pz;
  logic [tjdm_pkg::LIM_W-1:0]       m2;
  logic                             shake;
  logic [tjdm_pkg::TIME_W-1:0]      elapsed;
  logic                             toggle;
  logic                             lift_state_r;
  logic [tjdm_pkg::TIME_W-1:0]      last_toggle_r;

  assign px = 32'(accel_x) * 32'(accel_x);
  assign py = 32'(accel_y) * 32'(accel_y);
  assign pz = 32'(accel_z) * 32'(accel_z);
  // each square is at most 2^30, so the sum fits 32 bits unsigned
  assign m2 = $unsigned(px) + $unsigned(py) + $unsigned(pz);

  assign shake   = (m2 > lim.hi) || (lim.lo_en && (m2 < lim.lo));
  assign elapsed = time_ms - last_toggle_r;
  assign toggle  = shake && (elapsed > 32'(holdoff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lift_state_r  <= 1'b0;
      last_toggle_r <= '0;
    end else if (adv && toggle) begin
      lift_state_r  <= ~lift_state_r;
      last_toggle_r <= time_ms;
    end
  end

  assign lift_up = lift_state_r ^ toggle;
  assign toggled = toggle;

  `ASSERT_CLK(a_lift_hold, !adv |=> $stable(lift_state_r) && $stable(last_toggle_r), "lift state moved without an item")
  `ASSERT_CLK(a_lift_flip, adv && toggle |=> lift_state_r != $past(lift_state_r), "toggle did not flip lift")
  `ASSERT_CLK(a_lift_stamp, adv && toggle |=> last_toggle_r == $past(time_ms), "toggle time not stamped")

endmodule

// ----- src/tilt_joystick_drive_mixer.sv -----
// Top level of the tilt joystick drive mixer: config registers, item and
// result registers. Depends on tjdm_pkg, tjdm_shake_lim, tjdm_wheel, tjdm_lift.
//
// Use: each item on the in_ stream is one accelerometer sample (x, y, z at
// 9810 counts per g) plus a millisecond time stamp. Each item gives exactly
// one result on the out_ stream: left and right wheel speeds in 1/16 mm/s
// after the dead zone, the lift state, a toggle flag and the head angle.
// Path: an accepted item is held in the item register and worked on there, and
// its result is registered into the result register, which drives out_tvalid.
// Throughput: one item per cycle unless held off by a stall or settling; the
// item register and the result register move together, so an item is taken
// while a result waits if that result leaves in the same cycle.
// Stall: with out_tready low the result holds and the item register fills;
// in_tready then drops until out_tready returns.
// Config: cfg_ready is always high. After any write, and after reset, in_tready
// stays low while the three-stage shake limit pipeline settles.
// Reset (rst_n low, synchronous): registers take their reset values, the
// lift goes down, the last toggle time is zero and both stages empty.
`include "assert_macros.svh"

module tilt_joystick_drive_mixer (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32], time_ms [79:48]
  input  logic [tjdm_pkg::IN_TDATA_W-1:0]        in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // left_speed [15:0], right_speed [31:16], lift_up [32], lift_toggled [33],
  // head_angle [44:34], zero fill [47:45]
  output logic [tjdm_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tjdm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tjdm_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // config registers
  logic [tjdm_pkg::THR_W-1:0]          thr_r;
  logic [tjdm_pkg::DZ_W-1:0]           dz_r;
  logic [tjdm_pkg::HOLD_W-1:0]         hold_r;
  logic signed [tjdm_pkg::ANGLE_W-1:0] angle_hi_r, angle_lo_r;
  logic [1:0]                          settle_cnt_r, settle_cnt_nxt;
  logic                                cfg_wr;

  // item and result stages
  logic                                s1_valid_r, s1_valid_nxt;
  logic [tjdm_pkg::IN_TDATA_W-1:0]     s1_data_r;
  logic                                s1_adv;
  logic                                in_acc;
  logic                                out_tvalid_r, out_tvalid_nxt;
  logic [tjdm_pkg::OUT_TDATA_W-1:0]    out_data_r, out_data_nxt;

  logic signed [tjdm_pkg::AXIS_W-1:0]  ax, ay, az;
  logic [tjdm_pkg::TIME_W-1:0]         t_ms;
  logic signed [tjdm_pkg::SUM_W-1:0]   sum_l, sum_r;
  logic signed [tjdm_pkg::SPEED_W-1:0] speed_l, speed_r;
  logic                                lift_up, lift_tog;
  logic signed [tjdm_pkg::ANGLE_W-1:0] head;
  tjdm_pkg::shake_lim_t                lim;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= tjdm_pkg::THR_RST;
      dz_r       <= tjdm_pkg::DZ_RST;
      hold_r     <= tjdm_pkg::HOLD_RST;
      angle_hi_r <= tjdm_pkg::ANGLE_HIGH_RST;
      angle_lo_r <= tjdm_pkg::ANGLE_LOW_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        tjdm_pkg::REG_SHAKE_THR:  thr_r      <= cfg_data[tjdm_pkg::THR_W-1:0];
        tjdm_pkg::REG_DEAD_ZONE:  dz_r       <= cfg_data[tjdm_pkg::DZ_W-1:0];
        tjdm_pkg::REG_HOLDOFF:    hold_r     <= cfg_data[tjdm_pkg::HOLD_W-1:0];
        tjdm_pkg::REG_ANGLE_HIGH: angle_hi_r <= cfg_data[tjdm_pkg::ANGLE_W-1:0];
        tjdm_pkg::REG_ANGLE_LOW:  angle_lo_r <= cfg_data[tjdm_pkg::ANGLE_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // hold input off while the shake limits catch up with the threshold
  assign settle_cnt_nxt = cfg_wr                 ? tjdm_pkg::SETTLE_CYC :
                          (settle_cnt_r != 2'd0) ? settle_cnt_r - 2'd1  : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_cnt_r <= tjdm_pkg::SETTLE_CYC;
    end else begin
      settle_cnt_r <= settle_cnt_nxt;
    end
  end

  tjdm_shake_lim u_lim (
    .clk (clk),
    .thr (thr_r),
    .lim (lim)
  );

  // handshake: the item stage moves on when the result register is empty or its result is leaving
  assign s1_adv    = s1_valid_r && (!out_tvalid_r || out_tready);
  assign in_tready = (settle_cnt_r == 2'd0) && (!s1_valid_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt   = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_tvalid_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // unpack the held item
  assign ax   = $signed(s1_data_r[15:0]);
  assign ay   = $signed(s1_data_r[31:16]);
  assign az   = $signed(s1_data_r[47:32]);
  assign t_ms = s1_data_r[79:48];

  // mixing: left = y - x, right = -x - y, both exact in 18 bits
  assign sum_l = {{2{ay[15]}}, ay} - {{2{ax[15]}}, ax};
  assign sum_r = -{{2{ax[15]}}, ax} - {{2{ay[15]}}, ay};

  tjdm_wheel u_wheel_l (
    .sum       (sum_l),
    .dead_zone (dz_r),
    .speed     (speed_l)
  );

  tjdm_wheel u_wheel_r (
    .sum       (sum_r),
    .dead_zone (dz_r),
    .speed     (speed_r)
  );

  // lift state updates only when the item actually moves into the result
  tjdm_lift u_lift (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (s1_adv),
    .accel_x (ax),
    .accel_y (ay),
    .accel_z (az),
    .time_ms (t_ms),
    .lim     (lim),
    .holdoff (hold_r),
    .lift_up (lift_up),
    .toggled (lift_tog)
  );

  // head follows the lift state after this item
  assign head = lift_up ? angle_hi_r : angle_lo_r;

  assign out_data_nxt = {3'b000, head, lift_tog, lift_up, speed_r, speed_l};

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_RST(a_rst_empty, !rst_n |=> !s1_valid_r && !out_tvalid_r, "stages not empty after reset")
  `ASSERT_CLK(a_cfg_settle, cfg_valid |=> !in_tready, "item taken before limits settled")
  `ASSERT_CLK(a_s1_keep, s1_valid_r && !s1_adv |=> s1_valid_r, "held item lost")
  `ASSERT_CLK(a_out_src, $rose(out_tvalid_r) |-> $past(s1_valid_r), "result without an item")

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for tilt_joystick_drive_mixer: drives samples and register writes,
// predicts each wheel command and checks it field by field on the out_ stream.
// Depends on tjdm_pkg and the mixer RTL only.
module tb_top;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int RAND_PER_PHASE = 325;
  localparam int NUM_PHASES     = 6;
  localparam int LONG_HOLD_CYC  = 48;
  localparam int DRAIN_TAIL     = 8;

  localparam int AXIS_W   = tjdm_pkg::AXIS_W;
  localparam int TIME_W   = tjdm_pkg::TIME_W;
  localparam int IDX_W    = tjdm_pkg::CFG_IDX_W;
  localparam int DATA_W   = tjdm_pkg::CFG_DATA_W;

  // Holds the predicted mixer state and the queue of wheel commands still owed.
  class drive_mix_scoreboard;
    localparam int COUNTS_PER_G = 9810;
    localparam int SPEED_SCALE  = 4000;
    localparam int MILLI        = 1000;

    typedef struct packed {
      logic signed [tjdm_pkg::SPEED_W-1:0] left;
      logic signed [tjdm_pkg::SPEED_W-1:0] right;
      logic                                lift_up;
      logic                                toggled;
      logic signed [tjdm_pkg::ANGLE_W-1:0] head;
    } wheel_cmd_t;

    logic [tjdm_pkg::THR_W-1:0]          thr;
    logic [tjdm_pkg::DZ_W-1:0]           dz;
    logic [tjdm_pkg::HOLD_W-1:0]         hold;
    logic signed [tjdm_pkg::ANGLE_W-1:0] ang_hi;
    logic signed [tjdm_pkg::ANGLE_W-1:0] ang_lo;
    logic                                lift;
    logic [tjdm_pkg::TIME_W-1:0]         last_toggle;
    wheel_cmd_t                          cmd_q[$];
    int                                  fail_count;
    int                                  seen;

    function new();
      thr         = tjdm_pkg::THR_RST;
      dz          = tjdm_pkg::DZ_RST;
      hold        = tjdm_pkg::HOLD_RST;
      ang_hi      = tjdm_pkg::ANGLE_HIGH_RST;
      ang_lo      = tjdm_pkg::ANGLE_LOW_RST;
      lift        = 1'b0;
      last_toggle = '0;
      fail_count  = 0;
      seen        = 0;
    endfunction

    function void apply_reg(logic [tjdm_pkg::CFG_IDX_W-1:0] idx,
                            logic [tjdm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tjdm_pkg::REG_SHAKE_THR:  thr    = data[tjdm_pkg::THR_W-1:0];
        tjdm_pkg::REG_DEAD_ZONE:  dz     = data[tjdm_pkg::DZ_W-1:0];
        tjdm_pkg::REG_HOLDOFF:    hold   = data[tjdm_pkg::HOLD_W-1:0];
        tjdm_pkg::REG_ANGLE_HIGH: ang_hi = data[tjdm_pkg::ANGLE_W-1:0];
        tjdm_pkg::REG_ANGLE_LOW:  ang_lo = data[tjdm_pkg::ANGLE_W-1:0];
        default: ; // unused index, ignored
      endcase
    endfunction

    // round-to-nearest on the magnitude, dead zone, then sign and clamp
    function logic signed [tjdm_pkg::SPEED_W-1:0] wheel_speed(int sum);
      longint mag, q, v;
      mag = (sum < 0) ? -sum : sum;
      q   = (mag * SPEED_SCALE + COUNTS_PER_G / 2) / COUNTS_PER_G;
      v   = (q < longint'(dz)) ? 0 : q - longint'(dz);
      if (sum < 0) v = -v;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[tjdm_pkg::SPEED_W-1:0];
    endfunction

    // squared magnitude against (1 g +/- t)^2, no root
    function bit is_shaking(int x, int y, int z);
      longint unsigned m2, lhs, hi, lo;
      m2  = longint'(x) * x + longint'(y) * y + longint'(z) * z;
      lhs = m2 * 64'd1000000;
      hi  = (64'(MILLI) + thr) * COUNTS_PER_G;
      if (lhs > hi * hi) return 1'b1;
      if (thr < MILLI) begin
        lo = (64'(MILLI) - thr) * COUNTS_PER_G;
        if (lhs < lo * lo) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_sample(logic signed [tjdm_pkg::AXIS_W-1:0] x,
                              logic signed [tjdm_pkg::AXIS_W-1:0] y,
                              logic signed [tjdm_pkg::AXIS_W-1:0] z,
                              logic [tjdm_pkg::TIME_W-1:0] now);
      wheel_cmd_t                  c;
      logic [tjdm_pkg::TIME_W-1:0] since;
      since     = now - last_toggle; // modulo 2^32, safe across the wrap
      c.toggled = 1'b0;
      if (is_shaking(int'(x), int'(y), int'(z)) && since > {16'b0, hold}) begin
        lift        = ~lift;
        last_toggle = now;
        c.toggled   = 1'b1;
      end
      c.left    = wheel_speed(int'(y) - int'(x));
      c.right   = wheel_speed(-int'(x) - int'(y));
      c.lift_up = lift;
      c.head    = lift ? ang_hi : ang_lo;
      cmd_q.push_back(c);
    endfunction

    function int pending();
      return cmd_q.size();
    endfunction

    task report(string what, int got, int want);
      $display("%0t item %0d %s: got %0d, want %0d", $time, seen, what, got, want);
      fail_count++;
    endtask

    task check_result(logic [tjdm_pkg::OUT_TDATA_W-1:0] td);
      wheel_cmd_t want;
      seen++;
      if (cmd_q.size() == 0) begin
        report("unexpected result", int'($signed(td[15:0])), 0);
        return;
      end
      want = cmd_q.pop_front();
      if ($signed(td[15:0]) !== want.left)
        report("left_speed", int'($signed(td[15:0])), int'(want.left));
      if ($signed(td[31:16]) !== want.right)
        report("right_speed", int'($signed(td[31:16])), int'(want.right));
      if (td[32] !== want.lift_up)
        report("lift_up", int'(td[32]), int'(want.lift_up));
      if (td[33] !== want.toggled)
        report("lift_toggled", int'(td[33]), int'(want.toggled));
      if ($signed(td[44:34]) !== want.head)
        report("head_angle", int'($signed(td[44:34])), int'(want.head));
    endtask
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [tjdm_pkg::IN_TDATA_W-1:0]     in_tdata;
  logic                                out_tvalid;
  logic                                out_tready;
  logic [tjdm_pkg::OUT_TDATA_W-1:0]    out_tdata;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [IDX_W-1:0]                    cfg_index;
  logic [DATA_W-1:0]                   cfg_data;

  drive_mix_scoreboard sb;
  logic [TIME_W-1:0]   now_ms;
  int                  cycle_cnt = 0;
  bit                  long_hold_req = 1'b0;
  int                  hold_left = 0;
  int                  stall_left = 0;
  int                  ready_left = 0;
  int                  rx_roll;

  tilt_joystick_drive_mixer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: a long hold on request, otherwise runs of ready broken by
  // mostly short and a few long stalls
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left     = LONG_HOLD_CYC;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (ready_left > 0) begin
        ready_left--;
      end else begin
        ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120)
                                                 : $urandom_range(0, 6);
        rx_roll    = $urandom_range(0, 99);
        stall_left = (rx_roll < 70) ? $urandom_range(1, 2) :
                     (rx_roll < 94) ? $urandom_range(3, 6) : $urandom_range(12, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task send_sample(input logic signed [AXIS_W-1:0] x, input logic signed [AXIS_W-1:0] y,
                   input logic signed [AXIS_W-1:0] z, input logic [TIME_W-1:0] t,
                   input int gap);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {t, z, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(x, y, z, t);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering and wait until every owed result has left
  task drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task set_config(input int thr, input int dz, input int hold, input int hi, input int lo);
    drain();
    write_reg(tjdm_pkg::REG_SHAKE_THR, DATA_W'(thr));
    write_reg(tjdm_pkg::REG_DEAD_ZONE, DATA_W'(dz));
    write_reg(tjdm_pkg::REG_HOLDOFF, DATA_W'(hold));
    write_reg(tjdm_pkg::REG_ANGLE_HIGH, DATA_W'(hi));
    write_reg(tjdm_pkg::REG_ANGLE_LOW, DATA_W'(lo));
  endtask

  // mostly tilts near 1 g, some free fall, some anything at all
  task random_axes(output logic signed [AXIS_W-1:0] x, output logic signed [AXIS_W-1:0] y,
                   output logic signed [AXIS_W-1:0] z);
    int r, a;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      x = AXIS_W'(int'($urandom_range(0, 24000)) - 12000);
      y = AXIS_W'(int'($urandom_range(0, 24000)) - 12000);
      a = 9810 + int'($urandom_range(0, 6000)) - 3000;
      z = AXIS_W'($urandom_range(0, 1) ? a : -a);
    end else if (r < 75) begin
      x = AXIS_W'(int'($urandom_range(0, 6000)) - 3000);
      y = AXIS_W'(int'($urandom_range(0, 6000)) - 3000);
      z = AXIS_W'(int'($urandom_range(0, 6000)) - 3000);
    end else begin
      x = AXIS_W'($urandom());
      y = AXIS_W'($urandom());
      z = AXIS_W'($urandom());
    end
  endtask

  function void advance_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)      now_ms = now_ms + $urandom_range(0, 300);
    else if (r < 90) now_ms = now_ms + $urandom_range(300, 2000);
    else if (r < 97) now_ms = now_ms + $urandom_range(0, 70000);
    else             now_ms = $urandom();
  endfunction

  initial begin
    logic signed [AXIS_W-1:0] ax, ay, az;
    int gap;
    sb         = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    now_ms     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: holdoff edge, level, full-scale axes, dead zone, time wrap
    send_sample(0, 0, 0, 0, pick_gap());                   // free fall, holdoff not yet over
    send_sample(0, 0, 0, 750, pick_gap());                 // exactly the holdoff: no toggle
    send_sample(0, 0, 0, 751, pick_gap());                 // one past: lift up
    send_sample(0, 0, 9810, 2000, pick_gap());             // level, no shake
    send_sample(32767, 32767, 32767, 2000, pick_gap());    // hard shake, lift down
    send_sample(-32768, -32768, -32768, 2100, pick_gap()); // shake inside holdoff
    send_sample(32767, -32768, 0, 2200, pick_gap());
    send_sample(-32768, 32767, 0, 2300, pick_gap());
    send_sample(-32768, -32768, 9810, 2400, pick_gap());
    send_sample(3, -4, 9810, 2500, pick_gap());            // well inside dead zone
    send_sample(-300, 200, 9810, 2600, pick_gap());
    send_sample(0, 0, 0, 32'hFFFF_FF00, pick_gap());       // toggle just before wrap
    send_sample(0, 0, 0, 32'h0000_01EE, pick_gap());       // 750 across the wrap
    send_sample(0, 0, 0, 32'h0000_01EF, pick_gap());       // 751 across the wrap
    now_ms = 32'h0000_01EF;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: begin
          // zero threshold, no dead zone, no holdoff, widest angles
          set_config(0, 0, 0, 1000, -1000);
          send_sample(0, 0, 9810, now_ms + 10, pick_gap());  // exactly 1 g: no shake
          send_sample(0, 0, 9811, now_ms + 20, pick_gap());  // just above
          send_sample(0, 0, 9811, now_ms + 20, pick_gap());  // same ms as last toggle
          send_sample(0, 0, -9809, now_ms + 30, pick_gap()); // just below
          send_sample(1, 0, -9810, now_ms + 40, pick_gap()); // rounds to zero speed
          send_sample(2, 0, -9810, now_ms + 50, pick_gap()); // rounds to one
          now_ms = now_ms + 50;
        end
        2: begin
          // threshold above 1 g: free fall can no longer count as shake
          set_config(2000, 4095, 65535, -1000, 1000);
          send_sample(0, 0, 0, now_ms + 70000, pick_gap());
          send_sample(32767, -32768, 32767, now_ms + 140000, pick_gap());
          now_ms = now_ms + 140000;
        end
        3: begin
          set_config(1000, $urandom_range(0, 4095), $urandom_range(0, 1500),
                     int'($urandom_range(0, 2000)) - 1000, int'($urandom_range(0, 2000)) - 1000);
          // unused index, must change nothing
          write_reg(IDX_W'($urandom_range(int'(tjdm_pkg::REG_ANGLE_LOW) + 1, (1 << IDX_W) - 1)),
                    DATA_W'($urandom()));
          send_sample(0, 0, 0, now_ms + 2000, pick_gap());   // exactly 1 g threshold
          now_ms = now_ms + 2000;
        end
        0: ; // stay on reset settings
        default: begin
          set_config($urandom_range(0, 2000), $urandom_range(0, 4095), $urandom_range(0, 1500),
                     int'($urandom_range(0, 2000)) - 1000, int'($urandom_range(0, 2000)) - 1000);
        end
      endcase

      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (ph == 2 && i == 100) long_hold_req = 1'b1; // back-pressure until input stalls
        if (ph == 3 && i == 150) drain();              // sender waits for an empty pipe
        random_axes(ax, ay, az);
        advance_time();
        gap = ((ph == 2 && i >= 100 && i < 160) || (i % 100 < 15)) ? 0 : pick_gap();
        send_sample(ax, ay, az, now_ms, gap);
      end
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
